FILE: src/assert_macros.svh
// Assertion macros used by the checker file of the decimal formatter.
// Needs nothing else; the including file supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define PDF_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that holds through reset as well.
`define PDF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/pdfmt_pkg.sv
// Shared types and constants for the padded decimal formatter.
// Used by the controller, the datapath and the top level; depends on nothing.
package pdfmt_pkg;

  localparam int MAX_WIDTH  = 32;
  localparam int VALUE_BITS = 31;
  localparam int DIGITS_MAX = 10;
  localparam int BCD_W      = 4 * DIGITS_MAX;
  localparam int NDIG_W     = $clog2(DIGITS_MAX + 1);
  localparam int TOT_W      = $clog2(MAX_WIDTH + 1);
  localparam int REM_W      = $clog2(MAX_WIDTH);
  localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
  localparam int FW_W       = 6;
  localparam int FW_RESET   = 10;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;
  localparam int CHAR_W     = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;

  // Register index of field_width in the configuration map
  localparam logic [ADDR_W-3:0] REG_FIELD_WIDTH = '0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } pdfmt_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic shift;
    logic size;
    logic step;
  } pdfmt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last;
  } pdfmt_stat_t;

endpackage

FILE: src/pdfmt_ctrl.sv
// Controller state machine of the decimal formatter: sequences conversion,
// sizing and character output. Depends on pdfmt_pkg.
module pdfmt_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  pdfmt_pkg::pdfmt_stat_t stat,
  output pdfmt_pkg::pdfmt_cmd_t  cmd
);

  pdfmt_pkg::pdfmt_state_t state_r, state_nxt;
  logic [pdfmt_pkg::BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic conv_done;

  assign conv_done = (bit_cnt_r == pdfmt_pkg::BIT_CNT_W'(pdfmt_pkg::VALUE_BITS - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pdfmt_pkg::ST_IDLE: if (in_valid) state_nxt = pdfmt_pkg::ST_CONV;
      pdfmt_pkg::ST_CONV: if (conv_done) state_nxt = pdfmt_pkg::ST_SIZE;
      pdfmt_pkg::ST_SIZE: state_nxt = pdfmt_pkg::ST_EMIT;
      pdfmt_pkg::ST_EMIT: if (!out_stall && stat.last) state_nxt = pdfmt_pkg::ST_IDLE;
      default: state_nxt = pdfmt_pkg::ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    cmd         = '0;
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    bit_cnt_nxt = bit_cnt_r;
    unique case (state_r)
      pdfmt_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load    = in_valid;
        bit_cnt_nxt = '0;
      end
      pdfmt_pkg::ST_CONV: begin
        cmd.shift   = 1'b1;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
      end
      pdfmt_pkg::ST_SIZE: begin
        cmd.size = 1'b1;
      end
      pdfmt_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        cmd.step  = !out_stall && !stat.last;
      end
      default: ;
    endcase
  end

  // Hold state and conversion count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= pdfmt_pkg::ST_IDLE;
      bit_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      bit_cnt_r <= bit_cnt_nxt;
    end
  end

endmodule

FILE: src/pdfmt_dp.sv
// Datapath of the decimal formatter: shift-and-add-3 binary to BCD, digit
// count, padding count and character selection. Depends on pdfmt_pkg.
module pdfmt_dp (
  input  logic                                clk,
  input  logic [pdfmt_pkg::VALUE_BITS-1:0]    in_value,
  input  logic [pdfmt_pkg::FW_W-1:0]          field_width,
  input  pdfmt_pkg::pdfmt_cmd_t               cmd,
  output pdfmt_pkg::pdfmt_stat_t              stat,
  output logic [pdfmt_pkg::CHAR_W-1:0]        out_character,
  output logic                                out_last
);

  logic [pdfmt_pkg::VALUE_BITS-1:0] bin_r;
  logic [pdfmt_pkg::BCD_W-1:0]      bcd_r;
  logic [pdfmt_pkg::BCD_W-1:0]      bcd_adj;
  logic [pdfmt_pkg::NDIG_W-1:0]     nd_r, nd_cnt;
  logic [pdfmt_pkg::REM_W-1:0]      rem_r;
  logic [pdfmt_pkg::TOT_W-1:0]      width_sat, total;
  logic [3:0]                       dsel;
  logic [3:0]                       dig;

  // Add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < pdfmt_pkg::DIGITS_MAX; i++) begin
      dig = bcd_r[4*i +: 4];
      bcd_adj[4*i +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
    end
  end

  // Count significant digits, at least one
  always_comb begin
    nd_cnt = pdfmt_pkg::NDIG_W'(1);
    for (int i = 1; i < pdfmt_pkg::DIGITS_MAX; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) nd_cnt = pdfmt_pkg::NDIG_W'(i + 1);
    end
  end

  // Clamp the width and take the longer of width and digit count
  always_comb begin
    if ({1'b0, field_width} > (pdfmt_pkg::FW_W + 1)'(pdfmt_pkg::MAX_WIDTH)) begin
      width_sat = pdfmt_pkg::TOT_W'(pdfmt_pkg::MAX_WIDTH);
    end else begin
      width_sat = pdfmt_pkg::TOT_W'(field_width);
    end
    if (width_sat > pdfmt_pkg::TOT_W'(nd_cnt)) begin
      total = width_sat;
    end else begin
      total = pdfmt_pkg::TOT_W'(nd_cnt);
    end
  end

  // Load, convert, size and count down the characters
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r <= in_value;
      bcd_r <= '0;
    end else if (cmd.shift) begin
      bcd_r <= {bcd_adj[pdfmt_pkg::BCD_W-2:0], bin_r[pdfmt_pkg::VALUE_BITS-1]};
      bin_r <= {bin_r[pdfmt_pkg::VALUE_BITS-2:0], 1'b0};
    end
    if (cmd.size) begin
      nd_r  <= nd_cnt;
      rem_r <= pdfmt_pkg::REM_W'(total - 1'b1);
    end else if (cmd.step) begin
      rem_r <= rem_r - 1'b1;
    end
  end

  // Pick the digit that the down counter points at
  always_comb begin
    dsel = 4'd0;
    for (int i = 0; i < pdfmt_pkg::DIGITS_MAX; i++) begin
      if (rem_r[3:0] == 4'(i)) dsel = bcd_r[4*i +: 4];
    end
  end

  // Positions above the digit count are padding
  assign out_character = (pdfmt_pkg::TOT_W'(rem_r) >= pdfmt_pkg::TOT_W'(nd_r)) ?
                         pdfmt_pkg::ASCII_SPACE :
                         pdfmt_pkg::ASCII_ZERO + pdfmt_pkg::CHAR_W'(dsel);
  assign out_last  = (rem_r == '0);
  assign stat.last = out_last;

endmodule

FILE: src/padded_decimal_formatter.sv
// Padded decimal formatter: an item takes an accept step, the conversion steps
// and a sizing step, then one character per cycle while not stalled.
// No new item is taken until its last character has gone out; an item gives out
// max(field_width clamped to 32, digit count) characters.
// Synchronous active-low reset returns to idle and sets field_width to 10.
module padded_decimal_formatter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [pdfmt_pkg::VALUE_BITS-1:0]   in_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [pdfmt_pkg::CHAR_W-1:0]       out_character,
  output logic                               out_last,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pdfmt_pkg::ADDR_W-1:0]       paddr,
  input  logic [pdfmt_pkg::DATA_W-1:0]       pwdata,
  output logic [pdfmt_pkg::DATA_W-1:0]       prdata,
  output logic                               pready
);

  pdfmt_pkg::pdfmt_cmd_t  cmd;
  pdfmt_pkg::pdfmt_stat_t stat;
  logic [pdfmt_pkg::FW_W-1:0] field_width_r;
  logic                       fw_sel;

  assign pready = 1'b1;
  assign fw_sel = (paddr[pdfmt_pkg::ADDR_W-1:2] == pdfmt_pkg::REG_FIELD_WIDTH);

  // Write the field width register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_width_r <= pdfmt_pkg::FW_W'(pdfmt_pkg::FW_RESET);
    end else if (psel && penable && pwrite && pready && fw_sel) begin
      field_width_r <= pwdata[pdfmt_pkg::FW_W-1:0];
    end
  end

  // Read back
  assign prdata = fw_sel ? pdfmt_pkg::DATA_W'(field_width_r) : '0;

  pdfmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  pdfmt_dp u_dp (
    .clk           (clk),
    .in_value      (in_value),
    .field_width   (field_width_r),
    .cmd           (cmd),
    .stat          (stat),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

FILE: src/pdfmt_chk.sv
// Port-level checker for the padded decimal formatter, bound to the top level.
// Depends on assert_macros.svh and pdfmt_pkg.
`include "assert_macros.svh"

module pdfmt_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [pdfmt_pkg::CHAR_W-1:0]     out_character,
  input logic                             out_last
);

  // A stalled item holds
  `PDF_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_character) && $stable(out_last), "stalled output item changed")

  // No new item is taken while characters are going out
  `PDF_ASSERT_RST(a_busy_stall, clk, rst_n, out_valid |-> in_stall, "input accepted during output")

  // Conversion takes time after an accept
  `PDF_ASSERT_RST(a_no_early_out, clk, rst_n, in_valid && !in_stall |=> !out_valid, "output right after accept")

  // Characters of one number come without gaps, and stop after the last
  `PDF_ASSERT_RST(a_no_gap, clk, rst_n, out_valid && !out_stall && !out_last |=> out_valid, "gap inside a number")
  `PDF_ASSERT_RST(a_end, clk, rst_n, out_valid && !out_stall && out_last |=> !out_valid, "output after last character")

endmodule

bind padded_decimal_formatter pdfmt_chk u_chk (.*);
